/* src/assert_macros.svh */
// Assertion helpers shared by the RTL. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: invariant violated");
// Antecedent implies consequent; the consequent may carry its own delay
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("%m: implication violated");
`else
`define ASSERT_ALWAYS(label, expr)
`define ASSERT_IMPLIES(label, ante, cons)
`endif
`endif

/* src/lbs_pkg.sv */
package lbs_pkg;

    // fixed field widths
    localparam int LAMP_BITS_W = 18;
    localparam int ROW_FIELD_W = 4;
    localparam int LAMP_W      = 5;
    localparam int BRIGHT_W    = 5;
    localparam int LEVEL_W     = 16;
    localparam int SCALE_W     = 24;
    localparam int FACTOR_W    = 16;

    // configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // register reset values
    localparam logic [SCALE_W-1:0]  SCALE_RESET = 24'd33554;
    localparam logic [FACTOR_W-1:0] RISE_RESET  = 16'd61663;
    localparam logic [FACTOR_W-1:0] FALL_RESET  = 16'd64233;

    // brightness mapping: 0.1 in Q0.16 and slope of 31.5 / 0.9
    localparam logic [LEVEL_W-1:0]  LOW_POINT  = 16'd6554;
    localparam logic [5:0]          SLOPE      = 6'd35;
    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = 5'd31;

    typedef enum logic
    {
        MODE_SAMPLE = 1'b0,
        MODE_UPDATE = 1'b1
    } mode_t;

    typedef enum logic [1:0]
    {
        REG_TARGET_SCALE = 2'd0,
        REG_RISE_FACTOR  = 2'd1,
        REG_FALL_FACTOR  = 2'd2
    } reg_index_t;

    typedef struct packed
    {
        logic [SCALE_W-1:0]  target_scale;
        logic [FACTOR_W-1:0] rise_factor;
        logic [FACTOR_W-1:0] fall_factor;
    } cfg_t;

    // per-lane pipeline enables
    typedef struct packed
    {
        logic mul_en;
        logic mix_en;
    } lane_ctl_t;

    typedef struct packed
    {
        mode_t                  mode;
        logic [ROW_FIELD_W-1:0] row;
        logic [LAMP_BITS_W-1:0] lamp_bits;
    } item_t;

    typedef struct packed
    {
        logic [ROW_FIELD_W-1:0] out_row;
        logic [LAMP_W-1:0]      lamp;
        logic [BRIGHT_W-1:0]    brightness;
        logic                   last;
    } result_t;

endpackage

/* src/lbs_lane.sv */
module lbs_lane
    import lbs_pkg::*;
#(
    parameter int COUNT_BITS = 14
)
(
    input  logic                  clk,
    input  lane_ctl_t             ctl,
    input  cfg_t                  cfg,
    input  logic [COUNT_BITS-1:0] count,
    input  logic [LEVEL_W-1:0]    level,
    input  logic                  lamp_on,
    output logic [COUNT_BITS-1:0] count_inc,
    output logic [LEVEL_W-1:0]    level_new,
    output logic [BRIGHT_W-1:0]   brightness
);

    localparam int PROD_W = COUNT_BITS + SCALE_W;

    logic [PROD_W-1:0]  prod_reg;
    logic [LEVEL_W-1:0] cur_reg;
    logic [LEVEL_W-1:0] level_reg;

    logic [LEVEL_W-1:0]  target;
    logic [FACTOR_W-1:0] factor;
    logic signed [16:0]  diff;
    logic signed [33:0]  scaled;
    logic signed [33:0]  mix;
    logic [LEVEL_W-1:0]  span;
    logic [21:0]         span_prod;
    logic [5:0]          level_code;

    // saturating on-counter increment for a sample
    assign count_inc = (lamp_on && (count != {COUNT_BITS{1'b1}}))
                       ? count + COUNT_BITS'(1) : count;

    // stage 1: count times reciprocal window length
    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= PROD_W'(count) * PROD_W'(cfg.target_scale);
            cur_reg  <= level;
        end
    end

    // stage 2: asymmetric smoothing, cur*f + targ*(1-f) = targ + (cur-targ)*f
    always_comb
    begin
        target = (|prod_reg[PROD_W-1:SCALE_W]) ? {LEVEL_W{1'b1}} : prod_reg[SCALE_W-1:8];
        factor = (target >= cur_reg) ? cfg.rise_factor : cfg.fall_factor;
        diff   = $signed({1'b0, cur_reg}) - $signed({1'b0, target});
        scaled = diff * $signed({1'b0, factor});
        mix    = $signed({2'b00, target, 16'h0000}) + scaled;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mix_en)
        begin
            level_reg <= mix[31:16];
        end
    end

    assign level_new = level_reg;

    // map 0.1..1.0 onto 0..31.5, truncate and clamp
    always_comb
    begin
        span       = level_reg - LOW_POINT;
        span_prod  = 22'(span) * 22'(SLOPE);
        level_code = span_prod[21:16];
        if (level_reg <= LOW_POINT)
        begin
            brightness = '0;
        end
        else if (level_code > 6'(BRIGHT_MAX))
        begin
            brightness = BRIGHT_MAX;
        end
        else
        begin
            brightness = level_code[BRIGHT_W-1:0];
        end
    end

endmodule

/* src/lbs_merge.sv */
module lbs_merge
    import lbs_pkg::*;
#(
    parameter int LAMPS_PER_ROW = 18
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    load,
    input  logic [ROW_FIELD_W-1:0]                  load_row,
    input  logic [LAMPS_PER_ROW-1:0][BRIGHT_W-1:0]  bright,
    output logic                                    busy,
    output result_t                                 result,
    output logic                                    result_valid,
    input  logic                                    result_stall
);

    localparam int IDX_W = (LAMPS_PER_ROW > 1) ? $clog2(LAMPS_PER_ROW) : 1;

    logic [LAMPS_PER_ROW-1:0][BRIGHT_W-1:0] bright_reg;
    logic [ROW_FIELD_W-1:0]                 row_reg;
    logic [IDX_W-1:0]                       idx_reg;
    logic                                   active_reg;
    logic                                   out_valid_reg;
    result_t                                out_reg;

    logic advance;
    logic is_last;

    // next lamp moves into the output register when it is empty or drains
    assign advance = active_reg && (!out_valid_reg || !result_stall);
    assign is_last = (idx_reg == IDX_W'(LAMPS_PER_ROW - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                active_reg <= 1'b1;
                idx_reg    <= '0;
            end
            else if (advance)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
                if (is_last)
                begin
                    active_reg <= 1'b0;
                end
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // row snapshot and output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bright_reg <= bright;
            row_reg    <= load_row;
        end
        if (advance)
        begin
            out_reg.out_row    <= row_reg;
            out_reg.lamp       <= LAMP_W'(idx_reg);
            out_reg.brightness <= bright_reg[idx_reg];
            out_reg.last       <= is_last;
        end
    end

    assign busy         = active_reg;
    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule

/* src/lamp_brightness_smoother.sv */
// Incandescent lamp emulation for a front panel. A sample transfer (mode 0) adds one to
// the saturating on-counter of every lit lamp in its row: the row of counters is read
// from the count memory, then written back by all lanes at once. An update transfer
// (mode 1) runs every lamp of the row through its own lane (target multiply, smoothing
// multiply, brightness map), then the results leave one per cycle when the result side
// does not stall, lamp 0 first, so the next transfer is taken once the last lamp of an
// update has moved into the result register. A row index at or beyond ROWS is dropped.
// Counter and intensity rows start at zero after reset through per-row valid flags;
// there is no clearing pass. Registers sit at byte addresses 0 (target_scale), 4
// (rise_factor) and 8 (fall_factor) and should be written only while the block is idle.
`include "assert_macros.svh"

module lamp_brightness_smoother
    import lbs_pkg::*;
#(
    parameter int ROWS          = 10,
    parameter int LAMPS_PER_ROW = 18,
    parameter int COUNT_BITS    = 14
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  item_t              item,
    input  logic               item_valid,
    output logic               item_stall,
    output result_t            result,
    output logic               result_valid,
    input  logic               result_stall
);

    localparam int ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROW_NW   = $clog2(ROWS + 1);
    localparam int ROW_CW   = (ROW_NW > ROW_FIELD_W) ? ROW_NW : ROW_FIELD_W;

    typedef logic [LAMPS_PER_ROW-1:0][COUNT_BITS-1:0] cnt_row_t;
    typedef logic [LAMPS_PER_ROW-1:0][LEVEL_W-1:0]    lvl_row_t;

    // configuration
    cfg_t       cfg_reg;
    reg_index_t reg_sel;
    logic       cfg_write;

    // row memories with per-row valid flags
    cnt_row_t          cnt_mem [ROWS];
    lvl_row_t          lvl_mem [ROWS];
    logic [ROWS-1:0]   cnt_vld_reg;
    logic [ROWS-1:0]   lvl_vld_reg;
    cnt_row_t          cnt_rd_reg;
    lvl_row_t          lvl_rd_reg;
    logic              cnt_rv_reg;
    logic              lvl_rv_reg;

    // pipeline control and payload
    logic                   s1_valid_reg;
    logic                   s2_valid_reg;
    logic                   s3_valid_reg;
    mode_t                  s1_mode_reg;
    logic [ROW_AW-1:0]      s1_addr_reg;
    logic [ROW_AW-1:0]      s2_addr_reg;
    logic [ROW_AW-1:0]      s3_addr_reg;
    logic [ROW_FIELD_W-1:0] s1_row_reg;
    logic [ROW_FIELD_W-1:0] s2_row_reg;
    logic [ROW_FIELD_W-1:0] s3_row_reg;
    logic [LAMP_BITS_W-1:0] s1_bits_reg;

    logic [ROW_CW-1:0]      row_ext;
    logic [ROW_AW-1:0]      item_addr;
    logic                   in_range;
    logic                   accept;
    logic                   start;
    logic                   merge_busy;
    logic                   cnt_we;
    lane_ctl_t              lane_ctl;
    cnt_row_t               cnt_row;
    lvl_row_t               lvl_row;
    cnt_row_t               cnt_wdata;
    lvl_row_t               lvl_wdata;
    logic [LAMPS_PER_ROW-1:0]               lane_on;
    logic [LAMPS_PER_ROW-1:0][BRIGHT_W-1:0] bright_vec;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_sel   = reg_index_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{target_scale: SCALE_RESET, rise_factor: RISE_RESET,
                         fall_factor: FALL_RESET};
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_TARGET_SCALE: cfg_reg.target_scale <= pwdata[SCALE_W-1:0];
                REG_RISE_FACTOR:  cfg_reg.rise_factor  <= pwdata[FACTOR_W-1:0];
                REG_FALL_FACTOR:  cfg_reg.fall_factor  <= pwdata[FACTOR_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_TARGET_SCALE: prdata = PDATA_W'(cfg_reg.target_scale);
            REG_RISE_FACTOR:  prdata = PDATA_W'(cfg_reg.rise_factor);
            REG_FALL_FACTOR:  prdata = PDATA_W'(cfg_reg.fall_factor);
            default:          prdata = '0;
        endcase
    end

    // input decode; one transfer in flight at a time
    assign row_ext    = ROW_CW'(item.row);
    assign in_range   = row_ext < ROW_CW'(ROWS);
    assign item_addr  = row_ext[ROW_AW-1:0];
    assign item_stall = s1_valid_reg || s2_valid_reg || s3_valid_reg || merge_busy;
    assign accept     = item_valid && !item_stall;
    assign start      = accept && in_range;

    assign cnt_we          = s1_valid_reg && (s1_mode_reg == MODE_SAMPLE);
    assign lane_ctl.mul_en = s1_valid_reg && (s1_mode_reg == MODE_UPDATE);
    assign lane_ctl.mix_en = s2_valid_reg;

    // stage valids and valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            cnt_vld_reg  <= '0;
            lvl_vld_reg  <= '0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= lane_ctl.mul_en;
            s3_valid_reg <= s2_valid_reg;
            if (cnt_we)
            begin
                cnt_vld_reg[s1_addr_reg] <= 1'b1;
            end
            else if (lane_ctl.mul_en)
            begin
                // an update empties the row's counters
                cnt_vld_reg[s1_addr_reg] <= 1'b0;
            end
            if (s3_valid_reg)
            begin
                lvl_vld_reg[s3_addr_reg] <= 1'b1;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s1_mode_reg <= item.mode;
            s1_addr_reg <= item_addr;
            s1_row_reg  <= item.row;
            s1_bits_reg <= item.lamp_bits;
            cnt_rv_reg  <= cnt_vld_reg[item_addr];
            lvl_rv_reg  <= lvl_vld_reg[item_addr];
        end
        s2_addr_reg <= s1_addr_reg;
        s2_row_reg  <= s1_row_reg;
        s3_addr_reg <= s2_addr_reg;
        s3_row_reg  <= s2_row_reg;
    end

    // counter row memory
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[s1_addr_reg] <= cnt_wdata;
        end
        if (start)
        begin
            cnt_rd_reg <= cnt_mem[item_addr];
        end
    end

    // intensity row memory
    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            lvl_mem[s3_addr_reg] <= lvl_wdata;
        end
        if (start)
        begin
            lvl_rd_reg <= lvl_mem[item_addr];
        end
    end

    // rows never written read as zero
    assign cnt_row = cnt_rv_reg ? cnt_rd_reg : '0;
    assign lvl_row = lvl_rv_reg ? lvl_rd_reg : '0;

    // one lane per lamp of the row
    for (genvar j = 0; j < LAMPS_PER_ROW; j++)
    begin : g_lane
        if (j < LAMP_BITS_W)
        begin : g_bit
            assign lane_on[j] = s1_bits_reg[j];
        end
        else
        begin : g_nobit
            assign lane_on[j] = 1'b0;
        end

        lbs_lane #(
            .COUNT_BITS (COUNT_BITS)
        ) u_lane (
            .clk        (clk),
            .ctl        (lane_ctl),
            .cfg        (cfg_reg),
            .count      (cnt_row[j]),
            .level      (lvl_row[j]),
            .lamp_on    (lane_on[j]),
            .count_inc  (cnt_wdata[j]),
            .level_new  (lvl_wdata[j]),
            .brightness (bright_vec[j])
        );
    end

    // serialize the row into per-lamp results
    lbs_merge #(
        .LAMPS_PER_ROW (LAMPS_PER_ROW)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (s3_valid_reg),
        .load_row     (s3_row_reg),
        .bright       (bright_vec),
        .busy         (merge_busy),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    // checks
    `ASSERT_ALWAYS(a_single_in_flight, $onehot0({s1_valid_reg, s2_valid_reg, s3_valid_reg, merge_busy}))
    `ASSERT_IMPLIES(a_update_reaches_merge, start && (item.mode == MODE_UPDATE), ##4 merge_busy)
    `ASSERT_IMPLIES(a_sample_marks_row, cnt_we, ##1 cnt_vld_reg[$past(s1_addr_reg)])

endmodule
